// ----- hw/rtl/smf_pkg.sv -----
// Package for the sliding median filter: window size, field widths and types.
// No dependencies.
`default_nettype none

package smf_pkg;

    localparam int WINDOW = 5;
    localparam int VALUE_W = 32;
    localparam int TIME_W = 31;
    localparam int RANK = (WINDOW + 1) / 2;
    localparam int MID = (WINDOW - 1) / 2;
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CNT_W-1:0] t_count;

endpackage

`default_nettype wire

// ----- hw/rtl/smf_if.sv -----
// Valid/ready channel interfaces for the sliding median filter.
// Depends on smf_pkg.
`default_nettype none

interface smf_in_if
    import smf_pkg::*;
();
    logic   valid;
    logic   ready;
    t_value sample_value;
    t_time  sample_time;
    logic   restart;

    modport source (output valid, sample_value, sample_time, restart, input ready);
    modport sink (input valid, sample_value, sample_time, restart, output ready);
endinterface

interface smf_out_if
    import smf_pkg::*;
();
    logic   valid;
    logic   ready;
    t_value median_value;
    t_time  median_time;

    modport source (output valid, median_value, median_time, input ready);
    modport sink (input valid, median_value, median_time, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sliding_median_filter_core.sv -----
// Sliding-window median filter core: window registers, rank network, output register.
// Depends on smf_pkg and the channel interfaces in smf_if.sv.
//
// Usage:
//   i_in  carries timestamped samples (sample_value, sample_time, restart); a word
//         is taken at a rising edge with valid and ready high.
//   o_out carries one result per sample once the window holds WINDOW samples
//         since reset or the last restart: the window median and the timestamp
//         of the window's middle entry. The first WINDOW-1 samples give nothing.
//   restart empties the window before its own sample enters.
// Pipeline: the window registers shift when the sample is taken, and the rank
//   network then feeds the output register once that register is free.
// Throughput: one word per cycle while o_out is not stalled, set by the
//   combinational all-pairs compare network over the WINDOW entries.
// Reset clears the fill count and both valid flags; window contents are left
//   as they are and are never read before being written.
// Stall: the output register holds its word while o_out.ready is low; samples
//   are still taken until one of them yields a result, then i_in.ready drops
//   until the output drains.
`default_nettype none

module sliding_median_filter_core
    import smf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    smf_in_if.sink      i_in,
    smf_out_if.source   o_out
);

    t_value r_val [WINDOW];
    t_time  r_time [WINDOW];
    t_count r_fill;
    t_count n_fill;
    logic   r_calc_vld;
    logic   r_out_vld;
    t_value r_out_val;
    t_time  r_out_time;

    logic   in_acc;
    logic   out_free;
    t_count above [WINDOW];
    t_count at_or_above [WINDOW];
    t_value n_med;

    assign out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_calc_vld || out_free;
    assign in_acc = i_in.valid && i_in.ready;

    always_comb begin
        n_fill = i_in.restart ? '0 : r_fill;
        if (n_fill < t_count'(WINDOW)) begin
            n_fill = n_fill + t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_calc_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_fill <= n_fill;
                r_calc_vld <= (n_fill == t_count'(WINDOW));
            end else if (out_free) begin
                r_calc_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                r_val[i] <= r_val[i+1];
                r_time[i] <= r_time[i+1];
            end
            r_val[WINDOW-1] <= i_in.sample_value;
            r_time[WINDOW-1] <= i_in.sample_time;
        end
    end

    // all-pairs rank counts; lowest entry holding the rank wins
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            above[i] = '0;
            at_or_above[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                above[i] = above[i] + t_count'(r_val[j] > r_val[i]);
                at_or_above[i] = at_or_above[i] + t_count'(r_val[j] >= r_val[i]);
            end
        end
        n_med = r_val[0];
        for (int i = WINDOW - 1; i >= 0; i--) begin
            if (above[i] < t_count'(RANK) && t_count'(RANK) <= at_or_above[i]) begin
                n_med = r_val[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_calc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_calc_vld) begin
            r_out_val <= n_med;
            r_out_time <= r_time[MID];
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.median_value = r_out_val;
    assign o_out.median_time = r_out_time;

    a_calc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calc_vld |-> r_fill == t_count'(WINDOW))
        else $error("result pending with window not full");

    a_restart_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.restart) |=> !r_calc_vld && r_fill == t_count'(1))
        else $error("restart did not empty the window");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_count'(WINDOW))
        else $error("fill count beyond window");

    a_hold_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_calc_vld && !out_free) |=> r_calc_vld && $stable(r_fill))
        else $error("pending result lost while output stalled");

endmodule

`default_nettype wire
